// ===== sv/glyph_alpha_blend_renderer_core_defines.svh =====
// assertion macros for the glyph renderer
`ifndef GLYPH_ALPHA_BLEND_RENDERER_CORE_DEFINES_SVH
`define GLYPH_ALPHA_BLEND_RENDERER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GABR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GABR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GABR_ASSERT(lbl, clk, rst, prop, msg)
`define GABR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/gabr_pkg.sv =====
package gabr_pkg;

  localparam logic [7:0] FMT_1BPP = 8'h01;
  localparam logic [7:0] FMT_2BPP = 8'h82;
  localparam logic [7:0] FMT_8BPP = 8'h88;
  localparam logic [7:0] FMT_332  = 8'hA8;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_FG     = 2'd2;
  localparam logic [1:0] REG_BG     = 2'd3;

  localparam logic [7:0]  RST_FORMAT = FMT_1BPP;
  localparam logic [7:0]  RST_ROWS   = 8'd8;
  localparam logic [23:0] RST_FG     = 24'hFFFFFF;
  localparam logic [23:0] RST_BG     = 24'h000000;

  typedef struct packed {
    logic [7:0]  format_code;
    logic [7:0]  glyph_rows;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
  } cfg_t;

  typedef struct packed {
    logic       direct;
    logic [7:0] alpha_r;
    logic [7:0] alpha_g;
    logic [7:0] alpha_b;
    logic       last_of_byte;
    logic       last_of_glyph;
  } pix_t;

  function automatic logic [7:0] widen2(input logic [1:0] f);
    return (f == 2'd0) ? 8'd0 : {f, 6'h3F};
  endfunction

  function automatic logic [7:0] widen3(input logic [2:0] f);
    return (f == 3'd0) ? 8'd0 : {f, 5'h1F};
  endfunction

endpackage

// ===== sv/gabr_channels.sv =====
interface gabr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph_byte;
  logic       glyph_start;

  modport source (output valid, output glyph_byte, output glyph_start, input ready);
  modport sink   (input valid, input glyph_byte, input glyph_start, output ready);
endinterface

interface gabr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       last_of_byte;
  logic       last_of_glyph;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  output last_of_byte, output last_of_glyph, input ready);
  modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                  input last_of_byte, input last_of_glyph, output ready);
endinterface

interface gabr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/gabr_cfg.sv =====
module gabr_cfg (
  input  logic           clk,
  input  logic           rst,
  gabr_cfg_if.sink       cfg,
  output gabr_pkg::cfg_t regs
);
  import gabr_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.format_code <= RST_FORMAT;
      regs.glyph_rows  <= RST_ROWS;
      regs.fg_color    <= RST_FG;
      regs.bg_color    <= RST_BG;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FORMAT: regs.format_code <= cfg.data[7:0];
        REG_ROWS:   regs.glyph_rows  <= cfg.data[7:0];
        REG_FG:     regs.fg_color    <= cfg.data;
        REG_BG:     regs.bg_color    <= cfg.data;
        default:    ;
      endcase
    end
  end

endmodule

// ===== sv/gabr_expand.sv =====
`include "glyph_alpha_blend_renderer_core_defines.svh"

module gabr_expand (
  input  logic           clk,
  input  logic           rst,
  input  gabr_pkg::cfg_t regs,
  gabr_in_if.sink        glyph,
  output gabr_pkg::pix_t pix,
  output logic           pix_valid,
  input  logic           pix_ready
);
  import gabr_pkg::*;

  logic        busy;
  logic [7:0]  bits;
  logic [2:0]  cnt;
  logic [15:0] pixels_left;
  logic [7:0]  column_position;

  logic        advance;
  logic        emit;
  logic        finish;
  logic        accept;
  logic        known;
  logic [7:0]  col_inc;
  logic        col_end;
  logic [15:0] left_dec;
  logic [15:0] left_after;
  logic [15:0] glyph_size;
  logic [7:0]  alpha_r;
  logic [7:0]  alpha_g;
  logic [7:0]  alpha_b;
  logic        direct;
  logic        last_b;
  logic [7:0]  bits_next;

  always_comb begin
    advance  = !pix_valid || pix_ready;
    emit     = busy && advance;
    col_inc  = column_position + 8'd1;
    col_end  = col_inc >= regs.glyph_rows;
    left_dec = pixels_left - 16'd1;
    alpha_r  = 8'd0;
    alpha_g  = 8'd0;
    alpha_b  = 8'd0;
    direct   = 1'b0;
    last_b   = 1'b1;
    known    = 1'b1;
    bits_next = bits;
    unique case (regs.format_code)
      FMT_1BPP: begin
        alpha_r   = bits[7] ? 8'hFF : 8'h00;
        alpha_g   = alpha_r;
        alpha_b   = alpha_r;
        direct    = 1'b1;
        last_b    = (cnt == 3'd7) || (left_dec == 16'd0);
        bits_next = {bits[6:0], 1'b0};
      end
      FMT_2BPP: begin
        alpha_r   = widen2(bits[7:6]);
        alpha_g   = alpha_r;
        alpha_b   = alpha_r;
        last_b    = (cnt == 3'd3) || (left_dec == 16'd0) || col_end;
        bits_next = {bits[5:0], 2'b00};
      end
      FMT_8BPP: begin
        alpha_r = bits;
        alpha_g = bits;
        alpha_b = bits;
      end
      FMT_332: begin
        alpha_r = widen3(bits[7:5]);
        alpha_g = widen3(bits[4:2]);
        alpha_b = widen2(bits[1:0]);
      end
      default: known = 1'b0;
    endcase
    finish      = emit && last_b;
    glyph.ready = !busy || finish;
    accept      = glyph.valid && glyph.ready;
    left_after  = emit ? left_dec : pixels_left;
    glyph_size  = {8'd0, glyph.glyph_byte} * {8'd0, regs.glyph_rows};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      pix_valid       <= 1'b0;
      pixels_left     <= 16'd0;
      column_position <= 8'd0;
    end else begin
      if (advance) begin
        pix_valid <= emit;
      end
      if (emit) begin
        pixels_left     <= left_dec;
        column_position <= col_end ? 8'd0 : col_inc;
        if (last_b) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        if (glyph.glyph_start) begin
          pixels_left     <= glyph_size;
          column_position <= 8'd0;
          busy            <= 1'b0;
        end else begin
          busy <= known && (left_after != 16'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bits <= bits_next;
      cnt  <= cnt + 3'd1;
      pix  <= '{direct: direct, alpha_r: alpha_r, alpha_g: alpha_g, alpha_b: alpha_b,
                last_of_byte: last_b, last_of_glyph: (left_dec == 16'd0)};
    end
    if (accept && !glyph.glyph_start) begin
      bits <= glyph.glyph_byte;
      cnt  <= 3'd0;
    end
  end

  `GABR_ASSERT(a_busy_owes_pixels, clk, rst, busy |-> pixels_left != 16'd0, "busy with no pixels owed")
  `GABR_ASSERT(a_glyph_end_ends_byte, clk, rst, pix_valid && pix.last_of_glyph |-> pix.last_of_byte, "glyph end inside byte")
  `GABR_ASSERT(a_emit_counts_down, clk, rst, emit && !accept |=> pixels_left == $past(left_dec), "pixel count not decremented")
  `GABR_ASSERT(a_no_take_while_busy, clk, rst, busy && !finish |-> !accept, "request taken mid byte")

endmodule

// ===== sv/gabr_blend.sv =====
module gabr_blend (
  input  logic           clk,
  input  logic           rst,
  input  gabr_pkg::cfg_t regs,
  input  gabr_pkg::pix_t pix,
  input  logic           pix_valid,
  output logic           pix_ready,
  gabr_out_if.source     pixel
);
  import gabr_pkg::*;

  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] f,
                                     input logic [7:0] b);
    logic [15:0] s;
    s = ({8'd0, a} * {8'd0, f}) + ({8'd0, 8'hFF - a} * {8'd0, b});
    return s[15:8];
  endfunction

  always_comb begin
    pix_ready = !pixel.valid || pixel.ready;
    if (pix.direct) begin
      red   = pix.alpha_r[7] ? regs.fg_color[23:16] : regs.bg_color[23:16];
      green = pix.alpha_g[7] ? regs.fg_color[15:8]  : regs.bg_color[15:8];
      blue  = pix.alpha_b[7] ? regs.fg_color[7:0]   : regs.bg_color[7:0];
    end else begin
      red   = mix(pix.alpha_r, regs.fg_color[23:16], regs.bg_color[23:16]);
      green = mix(pix.alpha_g, regs.fg_color[15:8],  regs.bg_color[15:8]);
      blue  = mix(pix.alpha_b, regs.fg_color[7:0],   regs.bg_color[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (pix_ready) begin
      pixel.valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_valid) begin
      pixel.pixel_red     <= red;
      pixel.pixel_green   <= green;
      pixel.pixel_blue    <= blue;
      pixel.last_of_byte  <= pix.last_of_byte;
      pixel.last_of_glyph <= pix.last_of_glyph;
    end
  end

endmodule

// ===== sv/glyph_alpha_blend_renderer_core.sv =====
// Glyph renderer: a request with glyph_start set carries the glyph width and loads the
// pixel count (width times glyph_rows); later requests are glyph bytes that expand into
// blended RGB888 pixels, one pixel per clock unless stalled, in the font format held in
// format_code. A 1bpp byte gives up to eight pixels, a 2bpp byte up to four, an 8bpp or
// 3-3-2 byte one; start bytes, bytes outside a glyph and bytes in an unknown format are
// taken and give nothing. The next byte is taken in the cycle that the last pixel of the
// current one enters the expander's pixel register, so the pixel port runs at one pixel
// per clock unless stalled; pixels pass the expander and blend registers. Configuration
// writes are always taken and are to be made only while idle.
module glyph_alpha_blend_renderer_core (
  input  logic       clk,
  input  logic       rst,
  gabr_in_if.sink    glyph,
  gabr_out_if.source pixel,
  gabr_cfg_if.sink   cfg
);
  import gabr_pkg::*;

  cfg_t regs;
  pix_t pix;
  logic pix_valid;
  logic pix_ready;

  gabr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  gabr_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .glyph     (glyph),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready)
  );

  gabr_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pixel     (pixel)
  );

endmodule
